[sv/can_sfr_pkg.sv]
// Package: shared types, constants and codes for the CAN subscriber filter router.
`default_nettype none

package can_sfr_pkg;

  localparam int MAX_SUBSCRIBERS_DEF = 16;
  localparam int MAX_RESULTS         = 16;
  localparam int N_W                 = $clog2(MAX_RESULTS + 1);
  localparam int ID_W                = 29;
  localparam int DEST_W              = 8;
  localparam int DATA_W              = 64;
  localparam int BCNT_W              = 4;
  localparam int IDXF_W              = 4;
  localparam logic [BCNT_W-1:0] MAX_BYTES = BCNT_W'(8);

  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_NO_MATCH  = 2'd1,
    ST_ADDED     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_CMP,
    BS_DONE
  } back_state_t;

  typedef struct packed {
    logic              mode;
    logic              ext;
    logic [ID_W-1:0]   frame_or_sub_id;
    logic [ID_W-1:0]   sub_mask;
    logic [DEST_W-1:0] dest;
    logic [DATA_W-1:0] payload;
    logic [BCNT_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [DEST_W-1:0] out_dest;
    logic [IDXF_W-1:0] entry_index;
    logic [ID_W-1:0]   out_id;
    logic              out_ext;
    logic [DATA_W-1:0] out_payload;
    logic [BCNT_W-1:0] out_count;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              is_frame;
    logic              ext;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   mask;
    logic [DEST_W-1:0] dest;
    logic [DATA_W-1:0] payload;
    logic [BCNT_W-1:0] cnt;
  } q_item_t;

  typedef struct packed {
    logic              ext;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   mask;
    logic [DEST_W-1:0] dest;
  } entry_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

[sv/can_sfr_ifs.sv]
// Interfaces: valid/ready request channels for input items and result items.
`default_nettype none

interface can_sfr_in_if
  import can_sfr_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface can_sfr_out_if
  import can_sfr_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/can_sfr_front.sv]
// Front part: accept requests, classify and saturate them, and queue them for the back part.
`default_nettype none

module can_sfr_front
  import can_sfr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  can_sfr_in_if.sink  in_ch,
  output q_head_t     head,
  input  wire logic   pop
);

  q_item_t    q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] level_r, level_nxt;
  logic       push;
  q_item_t    cls;

  assign in_ch.ready = (level_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    cls.is_frame = in_ch.data.mode;
    cls.ext      = in_ch.data.ext;
    cls.id       = in_ch.data.frame_or_sub_id;
    cls.mask     = in_ch.data.sub_mask;
    cls.dest     = in_ch.data.dest;
    cls.payload  = in_ch.data.payload;
    cls.cnt      = (in_ch.data.byte_count > MAX_BYTES) ? MAX_BYTES : in_ch.data.byte_count;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 2'd1;
    end else if (pop && !push) begin
      level_nxt = level_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  assign head.valid = (level_r != 2'd0);
  assign head.item  = q_mem[rd_ptr_r];

endmodule

`default_nettype wire

[sv/can_sfr_back.sv]
// Back part: subscriber table, table walk and result register.
`default_nettype none

module can_sfr_back
  import can_sfr_pkg::*;
#(
  parameter int MAX_SUBSCRIBERS = MAX_SUBSCRIBERS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_head_t  head,
  output logic          pop,
  can_sfr_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_SUBSCRIBERS + 1);
  localparam int IDX_W = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SUBSCRIBERS);

  entry_t            tbl [MAX_SUBSCRIBERS];
  entry_t            rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  entry_t            wr_data;

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [N_W-1:0]    n_r, n_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [DEST_W-1:0] pend_dest_r, pend_dest_nxt;
  logic [CNT_W-1:0]  pend_idx_r, pend_idx_nxt;
  q_item_t           cur_r;
  logic              cur_ld;

  logic              out_v_r, out_v_nxt;
  out_item_t         out_r, out_res;
  logic              out_ld, out_free;

  logic              match, stall, stop;
  logic [CNT_W+IDXF_W-1:0] cnt_wide, pend_wide;

  assign out_free     = !out_v_r || out_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  assign idx_inc   = idx_r + CNT_W'(1);
  assign cnt_wide  = {{IDXF_W{1'b0}}, count_r};
  assign pend_wide = {{IDXF_W{1'b0}}, pend_idx_r};
  assign match     = (rd_data_r.ext == cur_r.ext) && ((cur_r.id & rd_data_r.mask) == rd_data_r.id);

  always_comb begin
    wr_data.ext  = head.item.ext;
    wr_data.id   = head.item.id;
    wr_data.mask = head.item.mask;
    wr_data.dest = head.item.dest;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_dest_nxt = pend_dest_r;
    pend_idx_nxt  = pend_idx_r;
    pop           = 1'b0;
    cur_ld        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    out_ld        = 1'b0;
    stall         = 1'b0;
    stop          = 1'b0;
    out_res.status      = ST_DELIVERED;
    out_res.out_dest    = pend_dest_r;
    out_res.entry_index = pend_wide[IDXF_W-1:0];
    out_res.out_id      = cur_r.id;
    out_res.out_ext     = cur_r.ext;
    out_res.out_payload = cur_r.payload;
    out_res.out_count   = cur_r.cnt;
    out_res.last        = 1'b0;
    case (state_r)
      BS_IDLE: begin
        if (head.valid) begin
          if (!head.item.is_frame) begin
            if (out_free) begin
              pop                 = 1'b1;
              out_ld              = 1'b1;
              out_res.out_dest    = head.item.dest;
              out_res.out_id      = head.item.id;
              out_res.out_ext     = head.item.ext;
              out_res.out_payload = '0;
              out_res.out_count   = '0;
              out_res.last        = 1'b1;
              if (count_r >= CNT_MAX) begin
                out_res.status      = ST_FULL;
                out_res.entry_index = '0;
              end else begin
                out_res.status      = ST_ADDED;
                out_res.entry_index = cnt_wide[IDXF_W-1:0];
                wr_en               = 1'b1;
                count_nxt           = count_r + CNT_W'(1);
              end
            end
          end else begin
            pop        = 1'b1;
            cur_ld     = 1'b1;
            idx_nxt    = '0;
            n_nxt      = '0;
            pend_v_nxt = 1'b0;
            if (count_r == '0) begin
              state_nxt = BS_DONE;
            end else begin
              rd_en     = 1'b1;
              state_nxt = BS_CMP;
            end
          end
        end
      end
      BS_CMP: begin
        stall = match && pend_v_r && !out_free;
        if (!stall) begin
          if (match) begin
            out_ld        = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_dest_nxt = rd_data_r.dest;
            pend_idx_nxt  = idx_r;
            n_nxt         = n_r + N_W'(1);
          end
          stop = (idx_inc == count_r) || (match && (n_r + N_W'(1) == N_W'(MAX_RESULTS)));
          if (stop) begin
            state_nxt = BS_DONE;
          end else begin
            idx_nxt = idx_inc;
            rd_en   = 1'b1;
            rd_addr = idx_inc[IDX_W-1:0];
          end
        end
      end
      BS_DONE: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_res.last = 1'b1;
          if (!pend_v_r) begin
            out_res.status      = ST_NO_MATCH;
            out_res.out_dest    = '0;
            out_res.entry_index = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
    out_v_nxt = out_ld ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_IDLE;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      idx_r    <= idx_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_dest_r <= pend_dest_nxt;
    pend_idx_r  <= pend_idx_nxt;
    if (cur_ld) begin
      cur_r <= head.item;
    end
    if (out_ld) begin
      out_r <= out_res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[count_r[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tbl[rd_addr];
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_IDLE) |-> !pend_v_r)
    else $error("pending match left over in idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("entry count beyond table size");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_CMP) |-> (idx_r < count_r))
    else $error("walk index beyond valid entries");

  a_match_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= N_W'(MAX_RESULTS))
    else $error("match count beyond result limit");

endmodule

`default_nettype wire

[sv/can_subscriber_filter_router.sv]
// Top level: CAN subscriber filter router, front classifier and queue plus back table walker.
// Add request: one result, loaded from the queue head into the result register once the output is free.
// Frame request: the back part walks the entries, one compared per cycle unless an output stall
// holds it, through the table memory's single registered read port; the walk ends after the last
// entry or at MAX_RESULTS matches. Reset clears the entry count, the request queue, the walker and
// the result register; table contents are left as they are and only entries below the count are read.
`default_nettype none

module can_subscriber_filter_router
  import can_sfr_pkg::*;
#(
  parameter int MAX_SUBSCRIBERS = MAX_SUBSCRIBERS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  can_sfr_in_if.sink    in_ch,
  can_sfr_out_if.source out_ch
);

  q_head_t head;
  logic    pop;

  can_sfr_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  can_sfr_back #(
    .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
